// ===== sv/wepm_pkg.sv =====
// Shared constants for the waveform extrema and period meter.
// No dependencies; used by waveform_extrema_period_meter_unit.
package wepm_pkg;

  // Default field widths
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned TIME_BITS_DEF   = 16;

  // Sequencer phase codes
  localparam int unsigned PHASE_BITS = 3;
  localparam logic [PHASE_BITS-1:0] PH_BASE_A = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_BASE_B = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_TROUGH = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_PEAK   = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_REF_A  = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_REF_B  = 3'd5;
  localparam logic [PHASE_BITS-1:0] PH_CHK_A  = 3'd6;
  localparam logic [PHASE_BITS-1:0] PH_CHK_B  = 3'd7;

endpackage

// ===== sv/waveform_extrema_period_meter_unit.sv =====
// Waveform extrema and period meter: top level, single module.
// Depends on wepm_pkg for default widths and phase codes.
//
// Takes one sample item per cycle, each with its timer stamp, and reports the
// trough, the peak and the period (stamp difference, modulo 2^TIME_BITS) once
// a full waveform cycle has been seen. An item passes an input register, then
// the phase sequencer and comparators update state and load the result
// register. The sustained rate is one item per cycle; input stall rises
// only when the result register is held by out_stall and the waiting item
// would produce a new result. No clearing pass is needed after reset.
module waveform_extrema_period_meter_unit #(
  parameter int unsigned SAMPLE_BITS = wepm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = wepm_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [TIME_BITS-1:0]   in_stamp,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_min_code,
  output logic [SAMPLE_BITS-1:0] out_max_code,
  output logic [TIME_BITS-1:0]   out_period_ticks
);

  // Input register
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [TIME_BITS-1:0]   stamp_r;

  // Sequencer state
  logic [wepm_pkg::PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] pair_first_r, pair_first_nxt;
  logic [SAMPLE_BITS-1:0] trough_r, trough_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                   trough_found_r, trough_found_nxt;
  logic                   peak_found_r, peak_found_nxt;
  logic [SAMPLE_BITS-1:0] ref_value_r, ref_value_nxt;
  logic [TIME_BITS-1:0]   start_stamp_r, start_stamp_nxt;

  // Result register
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_min_r;
  logic [SAMPLE_BITS-1:0] out_max_r;
  logic [TIME_BITS-1:0]   out_period_r;

  logic emit;       // the registered item completes a cycle
  logic out_free;   // result register can take a new result
  logic advance;    // registered item is consumed this cycle
  logic both_found;
  logic crossing;

  assign out_free   = !out_valid_r || !out_stall;
  assign advance    = in_valid_r && (!emit || out_free);
  assign in_stall   = in_valid_r && !advance;
  assign both_found = trough_found_r && peak_found_r;

  // Upward crossing through the reference value
  assign crossing = ((pair_first_r <= ref_value_r) && (sample_r > ref_value_r)) ||
                    ((pair_first_r < ref_value_r) && (sample_r >= ref_value_r));

  // Phase sequencer and extrema tracking
  always_comb begin
    phase_nxt        = phase_r;
    pair_first_nxt   = pair_first_r;
    trough_nxt       = trough_r;
    peak_nxt         = peak_r;
    trough_found_nxt = trough_found_r;
    peak_found_nxt   = peak_found_r;
    ref_value_nxt    = ref_value_r;
    start_stamp_nxt  = start_stamp_r;
    emit             = 1'b0;
    unique case (phase_r)
      wepm_pkg::PH_BASE_A: begin
        pair_first_nxt = sample_r;
        phase_nxt      = wepm_pkg::PH_BASE_B;
      end
      wepm_pkg::PH_BASE_B: begin
        if (pair_first_r > sample_r && !trough_found_r) begin
          trough_nxt = sample_r;
          phase_nxt  = wepm_pkg::PH_TROUGH;
        end else if (pair_first_r < sample_r && !peak_found_r) begin
          peak_nxt  = sample_r;
          phase_nxt = wepm_pkg::PH_PEAK;
        end else begin
          phase_nxt = both_found ? wepm_pkg::PH_REF_A : wepm_pkg::PH_BASE_A;
        end
      end
      wepm_pkg::PH_TROUGH: begin
        if (sample_r < trough_r) begin
          trough_nxt = sample_r;
        end else if (sample_r > trough_r) begin
          trough_found_nxt = 1'b1;
          phase_nxt = peak_found_r ? wepm_pkg::PH_REF_A : wepm_pkg::PH_BASE_A;
        end
      end
      wepm_pkg::PH_PEAK: begin
        if (sample_r > peak_r) begin
          peak_nxt = sample_r;
        end else if (sample_r < peak_r) begin
          peak_found_nxt = 1'b1;
          phase_nxt = trough_found_r ? wepm_pkg::PH_REF_A : wepm_pkg::PH_BASE_A;
        end
      end
      wepm_pkg::PH_REF_A: begin
        ref_value_nxt = sample_r;
        phase_nxt     = wepm_pkg::PH_REF_B;
      end
      wepm_pkg::PH_REF_B: begin
        start_stamp_nxt = stamp_r;
        phase_nxt       = wepm_pkg::PH_CHK_A;
      end
      wepm_pkg::PH_CHK_A: begin
        pair_first_nxt = sample_r;
        phase_nxt      = wepm_pkg::PH_CHK_B;
      end
      wepm_pkg::PH_CHK_B: begin
        if (crossing) begin
          emit             = 1'b1;
          trough_found_nxt = 1'b0;
          peak_found_nxt   = 1'b0;
          phase_nxt        = wepm_pkg::PH_BASE_A;
        end else begin
          phase_nxt = wepm_pkg::PH_CHK_A;
        end
      end
      default: phase_nxt = wepm_pkg::PH_BASE_A;
    endcase
  end

  // Input register: refills when empty or whenever the held item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!in_valid_r || advance) && in_valid) begin
      sample_r <= in_sample;
      stamp_r  <= in_stamp;
    end
  end

  // State update on each consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wepm_pkg::PH_BASE_A;
      pair_first_r   <= '0;
      trough_r       <= '0;
      peak_r         <= '0;
      trough_found_r <= 1'b0;
      peak_found_r   <= 1'b0;
      ref_value_r    <= '0;
      start_stamp_r  <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      pair_first_r   <= pair_first_nxt;
      trough_r       <= trough_nxt;
      peak_r         <= peak_nxt;
      trough_found_r <= trough_found_nxt;
      peak_found_r   <= peak_found_nxt;
      ref_value_r    <= ref_value_nxt;
      start_stamp_r  <= start_stamp_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_min_r    <= trough_r;
      out_max_r    <= peak_r;
      out_period_r <= stamp_r - start_stamp_r;  // wraps modulo 2^TIME_BITS
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_code     = out_min_r;
  assign out_max_code     = out_max_r;
  assign out_period_ticks = out_period_r;

endmodule
